/* rtl/bounded_deque_engine_top_defines.svh */
// Assertion macros for the bounded deque engine checker.
// Needs nothing; included by the checker file.
`ifndef BOUNDED_DEQUE_ENGINE_TOP_DEFINES_SVH
`define BOUNDED_DEQUE_ENGINE_TOP_DEFINES_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define BDE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bde check failed");

// The condition never holds out of reset.
`define BDE_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bde check failed");

`endif

/* rtl/bde_pkg.sv */
// Shared constants and types of the bounded deque engine.
// No dependencies.
package bde_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int WORD_W    = 32;
    localparam int OP_W      = 3;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

    // Value reported for a missing word.
    localparam logic signed [WORD_W-1:0] NOTHING = -32'sd1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_ram_ctl;

endpackage

/* rtl/bde_req_if.sv */
// Request and response channel interfaces of the bounded deque engine.
// Depends on bde_pkg.
interface bde_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [bde_pkg::OP_W-1:0]             op;
    logic signed [bde_pkg::WORD_W-1:0]    push_value;

    modport source (output valid, output op, output push_value, input ready);
    modport sink   (input valid, input op, input push_value, output ready);
endinterface

interface bde_rsp_if #(
    parameter int CNT_W = $clog2(bde_pkg::DEPTH_DEF + 1)
);
    logic                                 valid;
    logic                                 ready;
    logic signed [bde_pkg::WORD_W-1:0]    popped_value;
    logic                                 pop_done;
    logic signed [bde_pkg::WORD_W-1:0]    front_value;
    logic signed [bde_pkg::WORD_W-1:0]    back_value;
    logic [CNT_W-1:0]                     entry_count;
    logic                                 is_empty;
    logic                                 push_dropped;

    modport source (
        output valid, output popped_value, output pop_done, output front_value,
        output back_value, output entry_count, output is_empty, output push_dropped,
        input ready
    );
    modport sink (
        input valid, input popped_value, input pop_done, input front_value,
        input back_value, input entry_count, input is_empty, input push_dropped,
        output ready
    );
endinterface

/* rtl/bde_word_ram.sv */
// Word store: one write port and two registered read ports.
// Depends on bde_pkg.
module bde_word_ram #(
    parameter int DEPTH  = bde_pkg::DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                              i_clk,
    input  bde_pkg::t_ram_ctl                 i_ctl,
    input  logic [ADDR_W-1:0]                 i_waddr,
    input  logic signed [bde_pkg::WORD_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]                 i_raddr_a,
    input  logic [ADDR_W-1:0]                 i_raddr_b,
    output logic signed [bde_pkg::WORD_W-1:0] o_rdata_a,
    output logic signed [bde_pkg::WORD_W-1:0] o_rdata_b
);

    logic signed [bde_pkg::WORD_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

/* rtl/bde_ctrl.sv */
// Deque sequencer: pointer update, store write, front/back read, result register.
// Depends on bde_pkg and the channel interfaces.
module bde_ctrl #(
    parameter int DEPTH  = bde_pkg::DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int CNT_W  = $clog2(DEPTH + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    bde_req_if.sink                           i_req,
    bde_rsp_if.source                         o_rsp,
    output bde_pkg::t_ram_ctl                 o_ram_ctl,
    output logic [ADDR_W-1:0]                 o_waddr,
    output logic signed [bde_pkg::WORD_W-1:0] o_wdata,
    output logic [ADDR_W-1:0]                 o_raddr_a,
    output logic [ADDR_W-1:0]                 o_raddr_b,
    input  logic signed [bde_pkg::WORD_W-1:0] i_rdata_a,
    input  logic signed [bde_pkg::WORD_W-1:0] i_rdata_b
);

    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(DEPTH);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W:0]    SUM_WRAP  = (CNT_W + 1)'(DEPTH);

    // Ring position head + off, off below DEPTH.
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] head,
                                                  input logic [CNT_W-1:0]  off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(off);
        if (sum >= SUM_WRAP) begin
            sum = sum - SUM_WRAP;
        end
        return sum[ADDR_W-1:0];
    endfunction

    bde_pkg::t_state r_state, n_state;
    logic [ADDR_W-1:0] r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic signed [bde_pkg::WORD_W-1:0] r_popped, n_popped;
    logic r_pop_done, n_pop_done;
    logic r_dropped, n_dropped;
    logic signed [bde_pkg::WORD_W-1:0] r_front, r_back;
    logic r_out_valid;

    logic full;
    logic empty;
    logic load;
    logic [CNT_W-1:0] last_off;

    assign full     = (r_count == CNT_FULL);
    assign empty    = (r_count == '0);
    assign last_off = empty ? '0 : r_count - CNT_W'(1);
    assign load     = (r_state == bde_pkg::S_LOAD) && (!r_out_valid || o_rsp.ready);

    assign i_req.ready = (r_state == bde_pkg::S_IDLE);
    assign o_raddr_a   = r_head;
    assign o_raddr_b   = ring_add(r_head, last_off);
    assign o_wdata     = i_req.push_value;

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_popped   = r_popped;
        n_pop_done = r_pop_done;
        n_dropped  = r_dropped;
        o_ram_ctl  = '0;
        o_waddr    = r_head;
        unique case (r_state)
            bde_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_popped   = bde_pkg::NOTHING;
                    n_pop_done = 1'b0;
                    n_dropped  = 1'b0;
                    n_state    = bde_pkg::S_READ;
                    unique case (i_req.op)
                        bde_pkg::OP_PUSH_FRONT: begin
                            if (full) begin
                                n_dropped = 1'b1;
                            end else begin
                                n_head          = (r_head == '0) ? ADDR_LAST
                                                                 : r_head - ADDR_W'(1);
                                o_waddr         = n_head;
                                o_ram_ctl.wr_en = 1'b1;
                                n_count         = r_count + CNT_W'(1);
                            end
                        end
                        bde_pkg::OP_PUSH_BACK: begin
                            if (full) begin
                                n_dropped = 1'b1;
                            end else begin
                                o_waddr         = ring_add(r_head, r_count);
                                o_ram_ctl.wr_en = 1'b1;
                                n_count         = r_count + CNT_W'(1);
                            end
                        end
                        bde_pkg::OP_POP_FRONT: begin
                            if (!empty) begin
                                n_popped   = r_front;
                                n_pop_done = 1'b1;
                                n_head     = (r_head == ADDR_LAST) ? '0 : r_head + ADDR_W'(1);
                                n_count    = r_count - CNT_W'(1);
                            end
                        end
                        bde_pkg::OP_POP_BACK: begin
                            if (!empty) begin
                                n_popped   = r_back;
                                n_pop_done = 1'b1;
                                n_count    = r_count - CNT_W'(1);
                            end
                        end
                        default: begin
                            // query and unused codes: report state only
                        end
                    endcase
                end
            end
            bde_pkg::S_READ: begin
                o_ram_ctl.rd_en = 1'b1;
                n_state         = bde_pkg::S_LOAD;
            end
            bde_pkg::S_LOAD: begin
                if (load) begin
                    n_state = bde_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bde_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bde_pkg::S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_popped   <= n_popped;
        r_pop_done <= n_pop_done;
        r_dropped  <= n_dropped;
        if (load) begin
            // cache the end words for the next pop
            r_front              <= i_rdata_a;
            r_back               <= i_rdata_b;
            o_rsp.popped_value   <= r_popped;
            o_rsp.pop_done       <= r_pop_done;
            o_rsp.front_value    <= empty ? bde_pkg::NOTHING : i_rdata_a;
            o_rsp.back_value     <= empty ? bde_pkg::NOTHING : i_rdata_b;
            o_rsp.entry_count    <= r_count;
            o_rsp.is_empty       <= empty;
            o_rsp.push_dropped   <= r_dropped;
        end
    end

    assign o_rsp.valid = r_out_valid;

endmodule

/* rtl/bounded_deque_engine_top.sv */
// Bounded deque engine: ring buffer of DEPTH signed words, head pointer and count.
// An accepted request passes through the read and load states before its result is valid.
// A new request is taken only back in idle, after the accept/write step, the registered
// front/back read of the word memory and the result load; a waiting result holds the load.
// Synchronous active-low reset empties the deque; the word memory is not cleared.
module bounded_deque_engine_top #(
    parameter int DEPTH = bde_pkg::DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bde_req_if.sink   i_req,
    bde_rsp_if.source o_rsp
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    bde_pkg::t_ram_ctl                 ram_ctl;
    logic [ADDR_W-1:0]                 waddr;
    logic signed [bde_pkg::WORD_W-1:0] wdata;
    logic [ADDR_W-1:0]                 raddr_a;
    logic [ADDR_W-1:0]                 raddr_b;
    logic signed [bde_pkg::WORD_W-1:0] rdata_a;
    logic signed [bde_pkg::WORD_W-1:0] rdata_b;

    bde_ctrl #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_ram_ctl (ram_ctl),
        .o_waddr   (waddr),
        .o_wdata   (wdata),
        .o_raddr_a (raddr_a),
        .o_raddr_b (raddr_b),
        .i_rdata_a (rdata_a),
        .i_rdata_b (rdata_b)
    );

    bde_word_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_ctl     (ram_ctl),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

endmodule

/* rtl/bde_chk.sv */
// Port-level checker of the bounded deque engine, bound to the top level.
// Depends on bde_pkg and bounded_deque_engine_top_defines.svh.
`include "bounded_deque_engine_top_defines.svh"

module bde_chk #(
    parameter int DEPTH = bde_pkg::DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_rsp_valid,
    input logic signed [bde_pkg::WORD_W-1:0] i_popped_value,
    input logic                              i_pop_done,
    input logic signed [bde_pkg::WORD_W-1:0] i_front_value,
    input logic signed [bde_pkg::WORD_W-1:0] i_back_value,
    input logic [CNT_W-1:0]                  i_entry_count,
    input logic                              i_is_empty,
    input logic                              i_push_dropped
);

    `BDE_ASSERT_IMPLIES(a_empty_flag, i_clk, i_rst_n, i_rsp_valid, i_is_empty == (i_entry_count == '0))
    `BDE_ASSERT_IMPLIES(a_empty_ends, i_clk, i_rst_n, i_rsp_valid && i_is_empty, (i_front_value == bde_pkg::NOTHING) && (i_back_value == bde_pkg::NOTHING))
    `BDE_ASSERT_IMPLIES(a_no_pop_word, i_clk, i_rst_n, i_rsp_valid && !i_pop_done, i_popped_value == bde_pkg::NOTHING)
    `BDE_ASSERT_NEVER(a_pop_and_drop, i_clk, i_rst_n, i_rsp_valid && i_pop_done && i_push_dropped)

endmodule

bind bounded_deque_engine_top bde_chk #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
) u_bde_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_rsp_valid    (o_rsp.valid),
    .i_popped_value (o_rsp.popped_value),
    .i_pop_done     (o_rsp.pop_done),
    .i_front_value  (o_rsp.front_value),
    .i_back_value   (o_rsp.back_value),
    .i_entry_count  (o_rsp.entry_count),
    .i_is_empty     (o_rsp.is_empty),
    .i_push_dropped (o_rsp.push_dropped)
);

/* sim/testbench.sv */
// Self-checking testbench for the bounded deque engine: drives random and directed requests
// and compares every result against an in-bench ring buffer predictor.
// Depends on bde_pkg, the bde_req_if and bde_rsp_if interfaces and bounded_deque_engine_top.
module testbench;

    localparam int RING_DEPTH   = bde_pkg::DEPTH_DEF;
    localparam int CNT_W        = $clog2(RING_DEPTH + 1);
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_STALL   = 300;

    // Op codes 5 to 7 are spare and must behave as a query.
    localparam logic [bde_pkg::OP_W-1:0] OP_SPARE_LO  = 3'd5;
    localparam logic [bde_pkg::OP_W-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [bde_pkg::OP_W-1:0] OP_SPARE_HI  = 3'd7;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_SPARSE
    } t_rx_mode;

    typedef struct packed {
        logic signed [bde_pkg::WORD_W-1:0] popped;
        logic                              pop_done;
        logic signed [bde_pkg::WORD_W-1:0] front;
        logic signed [bde_pkg::WORD_W-1:0] back;
        logic [CNT_W-1:0]                  count;
        logic                              empty;
        logic                              dropped;
    } t_deque_result;

    logic i_clk;
    logic i_rst_n;

    bde_req_if                  req_ch ();
    bde_rsp_if #(.CNT_W(CNT_W)) rsp_ch ();

    bounded_deque_engine_top #(
        .DEPTH(RING_DEPTH)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    // Predictor copy of the deque
    logic signed [bde_pkg::WORD_W-1:0] ring_words [RING_DEPTH];
    int                                ring_head;
    int                                ring_count;
    t_deque_result                     pending_results [$];

    int fail_count      = 0;
    int checked_count   = 0;
    int request_count   = 0;
    int dropped_count   = 0;
    int empty_pop_count = 0;
    int peak_count      = 0;
    int burst_left      = 0;
    bit gaps_off        = 1'b0;
    int stall_orders    = 0;
    int stall_served    = 0;
    int cycle_count     = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_deque_result step_deque(
        input logic [bde_pkg::OP_W-1:0] op,
        input logic signed [bde_pkg::WORD_W-1:0] value);
        t_deque_result r;
        r.popped   = bde_pkg::NOTHING;
        r.pop_done = 1'b0;
        r.dropped  = 1'b0;
        case (op)
            bde_pkg::OP_PUSH_FRONT: begin
                if (ring_count >= RING_DEPTH) begin
                    r.dropped = 1'b1;
                end else begin
                    ring_head = (ring_head + RING_DEPTH - 1) % RING_DEPTH;
                    ring_words[ring_head] = value;
                    ring_count++;
                end
            end
            bde_pkg::OP_PUSH_BACK: begin
                if (ring_count >= RING_DEPTH) begin
                    r.dropped = 1'b1;
                end else begin
                    ring_words[(ring_head + ring_count) % RING_DEPTH] = value;
                    ring_count++;
                end
            end
            bde_pkg::OP_POP_FRONT: begin
                if (ring_count > 0) begin
                    r.popped   = ring_words[ring_head];
                    r.pop_done = 1'b1;
                    ring_head  = (ring_head + 1) % RING_DEPTH;
                    ring_count--;
                end
            end
            bde_pkg::OP_POP_BACK: begin
                if (ring_count > 0) begin
                    r.popped   = ring_words[(ring_head + ring_count - 1) % RING_DEPTH];
                    r.pop_done = 1'b1;
                    ring_count--;
                end
            end
            default: begin
            end
        endcase
        if (ring_count > 0) begin
            r.front = ring_words[ring_head];
            r.back  = ring_words[(ring_head + ring_count - 1) % RING_DEPTH];
        end else begin
            r.front = bde_pkg::NOTHING;
            r.back  = bde_pkg::NOTHING;
        end
        r.count = ring_count[CNT_W-1:0];
        r.empty = (ring_count == 0);
        return r;
    endfunction

    function automatic logic [bde_pkg::OP_W-1:0] pick_op(input int push_pct,
                                                         input int pop_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            return $urandom_range(0, 1) ? bde_pkg::OP_PUSH_BACK : bde_pkg::OP_PUSH_FRONT;
        else if (roll < push_pct + pop_pct)
            return $urandom_range(0, 1) ? bde_pkg::OP_POP_BACK : bde_pkg::OP_POP_FRONT;
        else
            return 3'($urandom_range(int'(bde_pkg::OP_QUERY), int'(OP_SPARE_HI)));
    endfunction

    function automatic logic signed [bde_pkg::WORD_W-1:0] pick_word();
        int roll;
        roll = $urandom_range(0, 15);
        if (roll == 0)
            return 32'sh7fffffff;
        else if (roll == 1)
            return 32'sh80000000;
        else if (roll == 2)
            return bde_pkg::NOTHING;
        else if (roll == 3)
            return '0;
        else
            return $urandom();
    endfunction

    // Offer one request, wait for its handshake and record what it must produce.
    task automatic send_request(input logic [bde_pkg::OP_W-1:0] op,
                                input logic signed [bde_pkg::WORD_W-1:0] value);
        int            gap;
        t_deque_result r;
        if (!gaps_off) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    req_ch.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
        end
        req_ch.valid      <= 1'b1;
        req_ch.op         <= op;
        req_ch.push_value <= value;
        do @(posedge i_clk); while (!req_ch.ready);
        r = step_deque(op, value);
        pending_results.insert(pending_results.size(), r);
        request_count++;
        if (r.dropped)
            dropped_count++;
        if ((op == bde_pkg::OP_POP_FRONT || op == bde_pkg::OP_POP_BACK) && !r.pop_done)
            empty_pop_count++;
        if (ring_count > peak_count)
            peak_count = ring_count;
    endtask

    // Hold the request side until every outstanding result has come back.
    task automatic wait_results_done();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic check_result(input t_deque_result exp_r);
        if (rsp_ch.popped_value !== exp_r.popped) begin
            $error("popped_value: expected %0d, got %0d", exp_r.popped, rsp_ch.popped_value);
            fail_count++;
        end
        if (rsp_ch.pop_done !== exp_r.pop_done) begin
            $error("pop_done: expected %0d, got %0d", exp_r.pop_done, rsp_ch.pop_done);
            fail_count++;
        end
        if (rsp_ch.front_value !== exp_r.front) begin
            $error("front_value: expected %0d, got %0d", exp_r.front, rsp_ch.front_value);
            fail_count++;
        end
        if (rsp_ch.back_value !== exp_r.back) begin
            $error("back_value: expected %0d, got %0d", exp_r.back, rsp_ch.back_value);
            fail_count++;
        end
        if (rsp_ch.entry_count !== exp_r.count) begin
            $error("entry_count: expected %0d, got %0d", exp_r.count, rsp_ch.entry_count);
            fail_count++;
        end
        if (rsp_ch.is_empty !== exp_r.empty) begin
            $error("is_empty: expected %0d, got %0d", exp_r.empty, rsp_ch.is_empty);
            fail_count++;
        end
        if (rsp_ch.push_dropped !== exp_r.dropped) begin
            $error("push_dropped: expected %0d, got %0d", exp_r.dropped, rsp_ch.push_dropped);
            fail_count++;
        end
        checked_count++;
    endtask

    initial begin : result_checker
        t_deque_result exp_r;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with no request pending: entry_count %0d",
                           rsp_ch.entry_count);
                    fail_count++;
                end else begin
                    exp_r = pending_results[0];
                    pending_results.delete(0);
                    check_result(exp_r);
                end
            end
        end
    end

    initial begin : result_receiver
        t_rx_mode mode;
        int       mode_left;
        int       stall_left;
        int       phase;
        mode       = RX_OPEN;
        mode_left  = 0;
        stall_left = 0;
        phase      = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_orders != stall_served) begin
                stall_served++;
                stall_left = LONG_STALL;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                phase++;
                case (mode)
                    RX_OPEN:     rsp_ch.ready <= 1'b1;
                    RX_COIN:     rsp_ch.ready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: rsp_ch.ready <= (phase % 4 != 0);
                    default:     rsp_ch.ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Empty-queue pops and peeks, field extremes, both ends, spare op codes.
    task automatic test_directed_corners();
        send_request(bde_pkg::OP_QUERY, 32'sd0);
        send_request(bde_pkg::OP_POP_FRONT, 32'sd123);
        send_request(bde_pkg::OP_POP_BACK, 32'sh55555555);
        send_request(bde_pkg::OP_PUSH_BACK, 32'sh7fffffff);
        send_request(bde_pkg::OP_PUSH_FRONT, 32'sh80000000);
        send_request(bde_pkg::OP_PUSH_BACK, bde_pkg::NOTHING);
        send_request(bde_pkg::OP_PUSH_FRONT, 32'sd0);
        send_request(bde_pkg::OP_QUERY, 32'shaaaaaaaa);
        send_request(OP_SPARE_LO, 32'sd7);
        send_request(OP_SPARE_MID, bde_pkg::NOTHING);
        send_request(OP_SPARE_HI, 32'sh7fffffff);
        // a popped word equal to -1 still reports pop_done
        send_request(bde_pkg::OP_POP_BACK, 32'sd0);
        send_request(bde_pkg::OP_POP_FRONT, 32'sd0);
        send_request(bde_pkg::OP_POP_BACK, 32'sd0);
        send_request(bde_pkg::OP_POP_FRONT, 32'sd0);
        send_request(bde_pkg::OP_POP_FRONT, 32'sd0);
        send_request(bde_pkg::OP_PUSH_FRONT, 32'sh12345678);
        send_request(bde_pkg::OP_POP_BACK, bde_pkg::NOTHING);
        send_request(bde_pkg::OP_PUSH_BACK, 32'shaaaaaaaa);
        send_request(bde_pkg::OP_POP_FRONT, 32'sh55555555);
        send_request(bde_pkg::OP_QUERY, bde_pkg::NOTHING);
    endtask

    // Balanced traffic keeps the deque near empty with frequent wrap of the head.
    task automatic test_random_mix();
        repeat (200) send_request(pick_op(40, 40), pick_word());
    endtask

    // Hold the response side off while requests keep coming, then drain.
    task automatic test_output_backpressure();
        gaps_off = 1'b1;
        stall_orders++;
        repeat (40) send_request(pick_op(60, 20), pick_word());
        gaps_off = 1'b0;
        wait_results_done();
    endtask

    // Push-heavy until full, then keep pushing so words get refused.
    task automatic test_fill_and_overflow();
        while (ring_count < RING_DEPTH)
            send_request(pick_op(93, 4), pick_word());
        repeat (40) send_request(pick_op(80, 10), pick_word());
        wait_results_done();
    endtask

    task automatic test_drain();
        repeat (150) send_request(pick_op(25, 65), pick_word());
    endtask

    initial begin : test_sequence
        i_rst_n           <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.op         <= bde_pkg::OP_QUERY;
        req_ch.push_value <= '0;
        ring_head  = 0;
        ring_count = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        test_random_mix();
        test_output_backpressure();
        test_fill_and_overflow();
        test_drain();

        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            fail_count++;
        end

        $display("Checked %0d results from %0d requests; peak occupancy %0d of %0d words.",
                 checked_count, request_count, peak_count, RING_DEPTH);
        $display("Refused pushes: %0d, pops on an empty deque: %0d.",
                 dropped_count, empty_pop_count);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/bde_pkg.sv
rtl/bde_req_if.sv
rtl/bde_word_ram.sv
rtl/bde_ctrl.sv
rtl/bounded_deque_engine_top.sv
rtl/bde_chk.sv
sim/testbench.sv
